// ===== rtl/core/rgnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgnp_pkg
// Shared types and constants for the radius-gated nearest point search.
// ----------------------------------------------------------------------------
package rgnp_pkg;

    localparam int PIX_W   = 16;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 2 * PIX_W;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_QUERY_X       = 2'd0,
        CFG_QUERY_Y       = 2'd1,
        CFG_SEARCH_RADIUS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } coord_t;

endpackage

// ===== rtl/core/rgnp_dist.sv =====
// ----------------------------------------------------------------------------
// rgnp_dist
// Squared axis distances from a point's pixel position to the query pixel.
// ----------------------------------------------------------------------------
module rgnp_dist
    import rgnp_pkg::*;
(
    input  logic signed [PIX_W-1:0]  pixel_x,
    input  logic signed [PIX_W-1:0]  pixel_y,
    input  logic signed [PIX_W-1:0]  query_x,
    input  logic signed [PIX_W-1:0]  query_y,
    output logic        [DIST_W-1:0] sq_x,
    output logic        [DIST_W-1:0] sq_y
);

    logic signed [PIX_W:0] dx;
    logic signed [PIX_W:0] dy;
    logic        [PIX_W:0] mag_x;
    logic        [PIX_W:0] mag_y;

    always_comb
    begin
        dx    = {pixel_x[PIX_W-1], pixel_x} - {query_x[PIX_W-1], query_x};
        dy    = {pixel_y[PIX_W-1], pixel_y} - {query_y[PIX_W-1], query_y};
        mag_x = dx[PIX_W] ? (PIX_W+1)'(-dx) : dx;
        mag_y = dy[PIX_W] ? (PIX_W+1)'(-dy) : dy;
        // magnitude never exceeds 2^16-1, so the top bit is always clear
        sq_x  = mag_x[PIX_W-1:0] * mag_x[PIX_W-1:0];
        sq_y  = mag_y[PIX_W-1:0] * mag_y[PIX_W-1:0];
    end

endmodule

// ===== rtl/core/radius_gated_nearest_point.sv =====
// ----------------------------------------------------------------------------
// radius_gated_nearest_point
// Keeps the world coordinates of the point nearest to a query pixel, inside
// an exclusive pixel radius, and reports them at the end of each run.
// ----------------------------------------------------------------------------
// Takes one point per clock cycle with no gaps needed. A point passes an input
// register, then a register holding its two squared axis distances, and is
// then added and compared against the running minimum. The result for a run
// is registered when its tlast item passes the compare stage, then it
// waits in the output register until taken. Input keeps flowing meanwhile
// until the next run's tlast item reaches the compare stage, which holds it
// there, and the input behind it, until the waiting result is taken.
// Ties keep the earlier point. With no point inside the radius, tdata is zero
// and the found flag is clear. Configuration writes apply to the next items.
module radius_gated_nearest_point
    import rgnp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], world_x[63:32], world_y[95:64], world_z[127:96]
    input  logic [127:0]         s_axis_tdata,
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // near_x[31:0], near_y[63:32], near_z[95:64]
    output logic [95:0]          m_axis_tdata,
    // found[0]
    output logic [0:0]           m_axis_tuser
);

    // configuration
    logic signed [PIX_W-1:0] query_x_reg;
    logic signed [PIX_W-1:0] query_y_reg;
    logic        [PIX_W-1:0] radius_reg;
    logic        [DIST_W-1:0] radius_sq_reg;

    // input stage
    logic                    v1_reg;
    logic signed [PIX_W-1:0] px1_reg;
    logic signed [PIX_W-1:0] py1_reg;
    coord_t                  w1_reg;
    logic                    last1_reg;

    // square stage
    logic                    v2_reg;
    logic [DIST_W-1:0]       sqx2_reg;
    logic [DIST_W-1:0]       sqy2_reg;
    coord_t                  w2_reg;
    logic                    last2_reg;

    // running search state
    logic [DIST_W-1:0]       best_dist_reg;
    logic [DIST_W-1:0]       best_dist_next;
    coord_t                  best_reg;
    coord_t                  best_next;
    logic                    found_reg;
    logic                    found_next;

    // output
    logic                    ov_reg;
    coord_t                  out_reg;
    logic                    out_found_reg;

    logic [DIST_W-1:0]       sq_x;
    logic [DIST_W-1:0]       sq_y;
    logic [DIST_W:0]         dist_sq;
    logic                    hit;
    logic                    out_free;
    logic                    s2_go;
    logic                    s2_ready;
    logic                    s1_go;
    logic                    s1_ready;
    logic                    in_go;

    assign out_free = !ov_reg || m_axis_tready;
    assign s2_go    = v2_reg && (!last2_reg || out_free);
    assign s2_ready = !v2_reg || s2_go;
    assign s1_go    = v1_reg && s2_ready;
    assign s1_ready = !v1_reg || s1_go;
    assign in_go    = s_axis_tvalid && s1_ready;

    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {out_reg.z, out_reg.y, out_reg.x};
    assign m_axis_tuser  = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg   <= '0;
            query_y_reg   <= '0;
            radius_reg    <= '0;
            radius_sq_reg <= '0;
        end
        else
        begin
            radius_sq_reg <= radius_reg * radius_reg;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_QUERY_X:       query_x_reg <= cfg_data;
                    CFG_QUERY_Y:       query_y_reg <= cfg_data;
                    CFG_SEARCH_RADIUS: radius_reg  <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    rgnp_dist u_dist (
        .pixel_x (px1_reg),
        .pixel_y (py1_reg),
        .query_x (query_x_reg),
        .query_y (query_y_reg),
        .sq_x    (sq_x),
        .sq_y    (sq_y)
    );

    always_comb
    begin
        dist_sq = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        hit     = (dist_sq < {1'b0, radius_sq_reg}) && (dist_sq < {1'b0, best_dist_reg});
        if (hit)
        begin
            best_dist_next = dist_sq[DIST_W-1:0];
            best_next      = w2_reg;
            found_next     = 1'b1;
        end
        else
        begin
            best_dist_next = best_dist_reg;
            best_next      = best_reg;
            found_next     = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            ov_reg        <= 1'b0;
            out_found_reg <= 1'b0;
            best_dist_reg <= '1;
            best_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                v1_reg <= s_axis_tvalid;
            if (s2_ready)
                v2_reg <= s1_go;

            if (s2_go)
            begin
                if (last2_reg)
                begin
                    // run ends: report and start over
                    best_dist_reg <= '1;
                    best_reg      <= '0;
                    found_reg     <= 1'b0;
                    out_found_reg <= found_next;
                    ov_reg        <= 1'b1;
                end
                else
                begin
                    best_dist_reg <= best_dist_next;
                    best_reg      <= best_next;
                    found_reg     <= found_next;
                    if (m_axis_tready)
                        ov_reg <= 1'b0;
                end
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            px1_reg   <= s_axis_tdata[15:0];
            py1_reg   <= s_axis_tdata[31:16];
            w1_reg.x  <= s_axis_tdata[63:32];
            w1_reg.y  <= s_axis_tdata[95:64];
            w1_reg.z  <= s_axis_tdata[127:96];
            last1_reg <= s_axis_tlast;
        end
        if (s1_go)
        begin
            sqx2_reg  <= sq_x;
            sqy2_reg  <= sq_y;
            w2_reg    <= w1_reg;
            last2_reg <= last1_reg;
        end
        if (s2_go && last2_reg)
            out_reg <= found_next ? best_next : '0;
    end

endmodule

// ===== rtl/core/rgnp_checker.sv =====
// ----------------------------------------------------------------------------
// rgnp_checker
// Port-level checks for radius_gated_nearest_point, bound to the top level.
// ----------------------------------------------------------------------------
module rgnp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a result waiting to be taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // nothing found means all-zero coordinates
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero coordinates with found clear");

    // input only backs up behind a blocked result
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind radius_gated_nearest_point rgnp_checker u_rgnp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
